FILE: rtl/scic_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the segment circle intersection core
// no dependencies

package scic_pkg;

  localparam int COORD_BITS = 24;
  localparam int MUL_CHUNK  = 26;

  typedef enum logic [1:0] {
    HIT_NONE = 2'd0,
    HIT_NEAR = 2'd1,
    HIT_FAR  = 2'd2
  } hit_code_t;

endpackage

FILE: rtl/scic_mul.sv
`timescale 1ns / 1ps
// two stage unsigned multiplier built from chunk partial products
// depends on scic_pkg for the default chunk width

module scic_mul #(
  parameter int AW = 51,
  parameter int BW = 46,
  parameter int CW = scic_pkg::MUL_CHUNK
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NA  = (AW + CW - 1) / CW;
  localparam int NB  = (BW + CW - 1) / CW;
  localparam int NP  = NA * NB;
  localparam int PW  = AW + BW;
  localparam int SUW = (NA + NB) * CW;

  logic [NA*CW-1:0] a_pad;
  logic [NB*CW-1:0] b_pad;
  logic [2*CW-1:0]  pp_r [NP];
  logic [SUW-1:0]   sum;
  logic [PW-1:0]    p_r;

  assign a_pad = (NA*CW)'(a_i);
  assign b_pad = (NB*CW)'(b_i);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= (2*CW)'(a_pad[i*CW +: CW]) * (2*CW)'(b_pad[j*CW +: CW]);
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SUW'(pp_r[i*NB+j]) << ((i + j) * CW));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum[PW-1:0];
    end
  end

  assign p_o = p_r;

endmodule

FILE: rtl/segment_circle_intersection_core.sv
`timescale 1ns / 1ps
// Segment versus circle intersection classifier. One transaction enters per cycle while
// in_stall is low; the six register stages are the coordinate differences, the component
// products, the quadratic coefficients, two stages of chunked wide products for the
// discriminant, and the final compare. A stall on a valid result freezes every stage at
// once, so it holds every transaction already in flight and raises in_stall.
// depends on scic_pkg and scic_mul

module segment_circle_intersection_core #(
  parameter int COORD_BITS = scic_pkg::COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic        [COORD_BITS-2:0] in_circle_radius,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_hit_code
);

  localparam int DW   = COORD_BITS + 1;
  localparam int MW   = 2 * DW;
  localparam int RW   = COORD_BITS - 1;
  localparam int R2W  = 2 * RW;
  localparam int SW   = 2 * COORD_BITS + 5;
  localparam int AW   = 2 * COORD_BITS + 1;
  localparam int ARW  = AW + R2W;
  localparam int CRW  = 2 * AW;

  typedef struct packed {
    logic a_zero;
    logic g_pos;
    logic g_lt_a;
    logic c_pos;
    logic c_neg;
  } side_t;

  logic en;
  logic [4:0] vld_r;
  logic out_valid_r;
  scic_pkg::hit_code_t code_r, code_nxt;

  // stage 1
  logic signed [DW-1:0] dx_r, dy_r, px_r, py_r;
  logic [RW-1:0] rad_r;

  // stage 2
  logic signed [MW-1:0] xx_nxt, yy_nxt, xp_nxt, yq_nxt, pxx_nxt, pyy_nxt, xq_nxt, yp_nxt;
  logic signed [MW-1:0] xx_r, yy_r, xp_r, yq_r, pxx_r, pyy_r, xq_r, yp_r;
  logic [R2W-1:0] r2_nxt, r2_r;

  // stage 3
  logic signed [SW-1:0] a_nxt, h_nxt, c_nxt, crp_nxt, crn_nxt;
  logic signed [SW-1:0] a_r, h_r, c_r;
  logic [AW-1:0] cr_abs_nxt, cr_abs_r;
  logic [R2W-1:0] r2_3_r;

  // stage 4 and 5 side path
  logic signed [SW-1:0] ah_sum, f1_nxt, f1_r;
  side_t side_nxt, side4_r, side5_r;
  logic f1_pos5_r, f1_neg5_r;

  // wide products
  logic [ARW-1:0] ar2;
  logic [CRW-1:0] cr2;
  logic [CRW-1:0] ar2_ext;
  logic d_neg, d_zero;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[3:0], in_valid};
      out_valid_r <= vld_r[4];
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= DW'(in_end_x) - DW'(in_start_x);
      dy_r  <= DW'(in_end_y) - DW'(in_start_y);
      px_r  <= DW'(in_start_x) - DW'(in_center_x);
      py_r  <= DW'(in_start_y) - DW'(in_center_y);
      rad_r <= in_circle_radius;
    end
  end

  // stage 2: component products
  assign xx_nxt  = MW'(dx_r) * MW'(dx_r);
  assign yy_nxt  = MW'(dy_r) * MW'(dy_r);
  assign xp_nxt  = MW'(dx_r) * MW'(px_r);
  assign yq_nxt  = MW'(dy_r) * MW'(py_r);
  assign pxx_nxt = MW'(px_r) * MW'(px_r);
  assign pyy_nxt = MW'(py_r) * MW'(py_r);
  assign xq_nxt  = MW'(dx_r) * MW'(py_r);
  assign yp_nxt  = MW'(dy_r) * MW'(px_r);
  assign r2_nxt  = R2W'(rad_r) * R2W'(rad_r);

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r  <= xx_nxt;
      yy_r  <= yy_nxt;
      xp_r  <= xp_nxt;
      yq_r  <= yq_nxt;
      pxx_r <= pxx_nxt;
      pyy_r <= pyy_nxt;
      xq_r  <= xq_nxt;
      yp_r  <= yp_nxt;
      r2_r  <= r2_nxt;
    end
  end

  // stage 3: quadratic coefficients and cross product magnitude
  assign a_nxt   = SW'(xx_r) + SW'(yy_r);
  assign h_nxt   = SW'(xp_r) + SW'(yq_r);
  assign c_nxt   = SW'(pxx_r) + SW'(pyy_r) - $signed(SW'(r2_r));
  assign crp_nxt = SW'(xq_r) - SW'(yp_r);
  assign crn_nxt = SW'(yp_r) - SW'(xq_r);
  assign cr_abs_nxt = crp_nxt[SW-1] ? crn_nxt[AW-1:0] : crp_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      h_r      <= h_nxt;
      c_r      <= c_nxt;
      cr_abs_r <= cr_abs_nxt;
      r2_3_r   <= r2_r;
    end
  end

  // stage 4 and 5: root position flags
  assign ah_sum = a_r + h_r;
  assign f1_nxt = a_r + c_r + (h_r <<< 1);

  always_comb begin
    side_nxt.a_zero = (a_r == '0);
    side_nxt.g_pos  = h_r[SW-1];
    side_nxt.g_lt_a = !ah_sum[SW-1] && (ah_sum != '0);
    side_nxt.c_pos  = !c_r[SW-1] && (c_r != '0);
    side_nxt.c_neg  = c_r[SW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r   <= side_nxt;
      f1_r      <= f1_nxt;
      side5_r   <= side4_r;
      f1_pos5_r <= !f1_r[SW-1] && (f1_r != '0);
      f1_neg5_r <= f1_r[SW-1];
    end
  end

  // stage 4 and 5: discriminant terms a*r^2 and cross^2
  scic_mul #(
    .AW (AW),
    .BW (R2W)
  ) u_mul_ar2 (
    .clk (clk),
    .en  (en),
    .a_i (a_r[AW-1:0]),
    .b_i (r2_3_r),
    .p_o (ar2)
  );

  scic_mul #(
    .AW (AW),
    .BW (AW)
  ) u_mul_cr2 (
    .clk (clk),
    .en  (en),
    .a_i (cr_abs_r),
    .b_i (cr_abs_r),
    .p_o (cr2)
  );

  // stage 6: classify
  assign ar2_ext = CRW'(ar2);
  assign d_neg   = ar2_ext < cr2;
  assign d_zero  = ar2_ext == cr2;

  always_comb begin
    code_nxt = scic_pkg::HIT_NONE;
    if (side5_r.a_zero || d_neg) begin
      code_nxt = scic_pkg::HIT_NONE;
    end else if (d_zero) begin
      if (side5_r.g_pos && side5_r.g_lt_a) begin
        code_nxt = scic_pkg::HIT_NEAR;
      end
    end else if (side5_r.g_pos && side5_r.c_pos && (side5_r.g_lt_a || f1_neg5_r)) begin
      code_nxt = scic_pkg::HIT_NEAR;
    end else if ((side5_r.g_pos || side5_r.c_neg) && side5_r.g_lt_a && f1_pos5_r) begin
      code_nxt = scic_pkg::HIT_FAR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r <= code_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit_code = code_r;

  // pipeline holds when frozen
  a_freeze_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r) && $stable(out_valid_r))
    else $error("pipeline valid bits moved while frozen");

  // a valid last stage reaches the output register
  a_valid_travel: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[4] |=> out_valid_r)
    else $error("transaction lost at output stage");

  // degenerate segment never hits
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(en && vld_r[4] && side5_r.a_zero)
      |-> code_r == scic_pkg::HIT_NONE)
    else $error("hit reported for degenerate segment");

  // tangent case never reports far root
  a_tangent: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(en && vld_r[4] && d_zero)
      |-> code_r != scic_pkg::HIT_FAR)
    else $error("far root reported on zero discriminant");

endmodule

FILE: bench/hit_code_checker.sv
`timescale 1ns / 1ps
// watches both channels of the segment circle intersection core, predicts each hit code
// and compares it against the returned one; depends on scic_pkg

module hit_code_checker #(
  parameter int CB = scic_pkg::COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [CB-1:0] in_center_x,
  input  logic signed [CB-1:0] in_center_y,
  input  logic        [CB-2:0] in_circle_radius,
  input  logic signed [CB-1:0] in_start_x,
  input  logic signed [CB-1:0] in_start_y,
  input  logic signed [CB-1:0] in_end_x,
  input  logic signed [CB-1:0] in_end_y,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_hit_code,
  output int                   mismatch_count,
  output int                   codes_pending
);

  localparam int WIDE = 160;
  typedef logic signed [WIDE-1:0] wide_t;

  scic_pkg::hit_code_t expected_codes[$];
  scic_pkg::hit_code_t want;
  int                  errs;

  function automatic scic_pkg::hit_code_t classify_segment(
    input logic signed [CB-1:0] cx,
    input logic signed [CB-1:0] cy,
    input logic        [CB-2:0] rad,
    input logic signed [CB-1:0] sx,
    input logic signed [CB-1:0] sy,
    input logic signed [CB-1:0] ex,
    input logic signed [CB-1:0] ey
  );
    wide_t dx, dy, px, py, r2, a, h, g, c, cr, disc, f1;
    dx   = wide_t'(ex) - wide_t'(sx);
    dy   = wide_t'(ey) - wide_t'(sy);
    px   = wide_t'(sx) - wide_t'(cx);
    py   = wide_t'(sy) - wide_t'(cy);
    r2   = wide_t'(rad) * wide_t'(rad);
    a    = dx * dx + dy * dy;
    h    = dx * px + dy * py;
    g    = -h;
    c    = px * px + py * py - r2;
    cr   = dx * py - dy * px;
    // quarter discriminant without the h*h - a*c cancellation
    disc = a * r2 - cr * cr;
    f1   = a + c + h + h;
    if (a == 0 || disc < 0) begin
      return scic_pkg::HIT_NONE;
    end else if (disc == 0) begin
      return (g > 0 && g < a) ? scic_pkg::HIT_NEAR : scic_pkg::HIT_NONE;
    end else if (g > 0 && c > 0 && (g < a || f1 < 0)) begin
      return scic_pkg::HIT_NEAR;
    end else if ((g > 0 || c < 0) && g < a && f1 > 0) begin
      return scic_pkg::HIT_FAR;
    end
    return scic_pkg::HIT_NONE;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, out_hit_code);
          errs++;
        end else begin
          want = expected_codes.pop_front();
          if (out_hit_code !== want) begin
            $display("%0t: hit_code mismatch, expected %0d, actual %0d",
                     $time, want, out_hit_code);
            errs++;
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        expected_codes.push_back(classify_segment(in_center_x, in_center_y, in_circle_radius,
                                                  in_start_x, in_start_y, in_end_x, in_end_y));
      end
    end
    mismatch_count <= errs;
    codes_pending  <= expected_codes.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// stimulus and verdict for the segment circle intersection core; directed geometry cases,
// then random queries; depends on scic_pkg, the core and hit_code_checker

module tb_top;

  localparam int CB        = scic_pkg::COORD_BITS;
  localparam int N_RANDOM  = 1630;
  localparam int HOLD_LEN  = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CB-1:0] in_center_x;
  logic signed [CB-1:0] in_center_y;
  logic        [CB-2:0] in_circle_radius;
  logic signed [CB-1:0] in_start_x;
  logic signed [CB-1:0] in_start_y;
  logic signed [CB-1:0] in_end_x;
  logic signed [CB-1:0] in_end_y;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_hit_code;
  int                   mismatch_count;
  int                   codes_pending;
  bit                   hold_now;

  segment_circle_intersection_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_circle_radius (in_circle_radius),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_code     (out_hit_code)
  );

  hit_code_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_circle_radius (in_circle_radius),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit_code     (out_hit_code),
    .mismatch_count   (mismatch_count),
    .codes_pending    (codes_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_query(
    input int cx,
    input int cy,
    input int rad,
    input int sx,
    input int sy,
    input int ex,
    input int ey
  );
    in_center_x      <= CB'(cx);
    in_center_y      <= CB'(cy);
    in_circle_radius <= (CB-1)'(rad);
    in_start_x       <= CB'(sx);
    in_start_y       <= CB'(sy);
    in_end_x         <= CB'(ex);
    in_end_y         <= CB'(ey);
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);
  endtask

  function automatic int offset_in(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic send_random_query();
    int kind, s, lim, cx, cy, rad, sx, sy, ex, ey;
    kind = $urandom_range(0, 99);
    s    = $urandom_range(2, 20);
    lim  = 1 << s;
    cx   = offset_in(1 << 22);
    cy   = offset_in(1 << 22);
    rad  = $urandom_range(0, lim);
    sx   = cx + offset_in(2 * lim);
    sy   = cy + offset_in(2 * lim);
    ex   = cx + offset_in(2 * lim);
    ey   = cy + offset_in(2 * lim);
    if (kind < 15) begin
      // raw bits over the full field ranges
      send_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind < 22) begin
      send_query(cx, cy, rad, sx, sy, sx, sy);
    end else if (kind < 32) begin
      // horizontal line touching the top of the circle
      sy = cy + rad;
      send_query(cx, cy, rad, cx - int'($urandom_range(0, 2 * lim)), sy,
                 cx + int'($urandom_range(0, 2 * lim)), sy);
    end else begin
      send_query(cx, cy, rad, sx, sy, ex, ey);
    end
  endtask

  // receiver: stall density is redrawn at the end of each random span, with one long hold-off
  initial begin
    int span, pct;
    bit hold_done;
    span      = 0;
    pct       = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_now && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
          endcase
        end
        out_stall <= ($urandom_range(0, 99) < pct);
        span--;
        @(posedge clk);
      end
    end
  end

  initial begin
    int sent, burst;
    hold_now         = 1'b0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_center_x      = '0;
    in_center_y      = '0;
    in_circle_radius = '0;
    in_start_x       = '0;
    in_start_y       = '0;
    in_end_x         = '0;
    in_end_y         = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate segment
    send_query(0, 0, 256, 100, 100, 100, 100);
    // crossing, exit only, fully inside, clear miss
    send_query(0, 0, 256, -1024, 0, 1024, 0);
    send_query(0, 0, 256, 0, 0, 1024, 0);
    send_query(0, 0, 256, -100, 0, 100, 0);
    send_query(0, 0, 256, -1024, 1000, 1024, 1000);
    // tangent inside the segment and at its start point
    send_query(0, 0, 256, -512, 256, 512, 256);
    send_query(0, 0, 256, 0, 256, 512, 256);
    // roots exactly on an end point
    send_query(0, 0, 256, 256, 0, 1024, 0);
    send_query(0, 0, 256, -1024, 0, -256, 0);
    // zero radius
    send_query(0, 0, 0, -256, 0, 256, 0);
    send_query(0, 0, 0, 0, 0, 256, 0);
    // field extremes
    send_query(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    send_query(-8388608, -8388608, 0, -8388608, -8388608, -8388608, -8388608);
    send_query(0, 0, 8388607, -8388608, -8388608, 8388607, 8388607);
    send_query(-8388608, 8388607, 8388607, 8388607, -8388608, -8388608, 8388607);
    send_query(8388607, -8388608, 1, -8388608, 8388607, 8388607, -8388608);
    // both roots behind, both roots past the end, entry only, inside a huge circle, off-centre crossing
    send_query(0, 0, 256, 1024, 0, 2048, 0);
    send_query(0, 0, 256, -2048, 0, -1024, 0);
    send_query(0, 0, 256, -1024, 0, 0, 0);
    send_query(0, 0, 8388607, -100, -100, 100, 100);
    send_query(300, -200, 500, 400, -2000, 400, 2000);
    drain_results();

    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_random_query();
        sent++;
        if (sent == 500) hold_now = 1'b1;
      end
      if (sent >= 1000 && sent - burst < 1000) begin
        drain_results();
      end else if ($urandom_range(0, 3) != 0) begin
        idle_sender($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && codes_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/scic_pkg.sv
rtl/scic_mul.sv
rtl/segment_circle_intersection_core.sv
bench/hit_code_checker.sv
bench/tb_top.sv
